FILE: src/dkcl_pkg.sv
`default_nettype none

package dkcl_pkg;

	// number of key pins walked per scan tick (1 to 16)
	localparam int NUM_KEYS = 10;
	// width of the pin and mask fields
	localparam int MASK_W = 10;
	localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	// key vector wide enough for both the keys and the mask fields
	localparam int KEY_VEC_W = (NUM_KEYS > MASK_W) ? NUM_KEYS : MASK_W;
	localparam int CODE_LEN = 4;
	localparam int DIGIT_W = 4;
	localparam int POS_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 3'd5;

	localparam logic [CFG_W-1:0] DEBOUNCE_MAX_RST = 4'd10;
	localparam logic [CFG_W-1:0] PRESS_THRESHOLD_RST = 4'd5;

	// input action codes
	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic action;
		logic [MASK_W-1:0] key_pins_n;
	} in_t;

	typedef struct packed {
		logic [MASK_W-1:0] released_mask;
		logic [MASK_W-1:0] pressed_mask;
		logic [POS_W-1:0] match_count;
		logic unlocked;
		logic newly_unlocked;
	} out_t;

	// result of one integrator update
	typedef struct packed {
		logic [CFG_W-1:0] level;
		logic now_pressed;
		logic released;
	} key_upd_t;

	// code matcher status
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic correct;
		logic completed;
	} match_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

FILE: src/dkcl_key_unit.sv
`default_nettype none

// shared integrator update, used for one key per cycle
module dkcl_key_unit (
	input  wire logic [dkcl_pkg::CFG_W-1:0] level,
	input  wire logic held,
	input  wire logic was_pressed,
	input  wire logic [dkcl_pkg::CFG_W-1:0] debounce_max,
	input  wire logic [dkcl_pkg::CFG_W-1:0] press_threshold,
	output dkcl_pkg::key_upd_t upd
);

	logic [dkcl_pkg::CFG_W:0] inc;
	logic [dkcl_pkg::CFG_W-1:0] next_level;

	always_comb begin
		inc = {1'b0, level} + {{dkcl_pkg::CFG_W{1'b0}}, 1'b1};
		if (held) begin
			if (inc >= {1'b0, debounce_max}) begin
				next_level = debounce_max;
			end else begin
				next_level = inc[dkcl_pkg::CFG_W-1:0];
			end
		end else if (level == '0) begin
			next_level = '0;
		end else begin
			next_level = level - {{(dkcl_pkg::CFG_W-1){1'b0}}, 1'b1};
		end
		upd.level = next_level;
		upd.now_pressed = (next_level >= press_threshold);
		upd.released = was_pressed & ~upd.now_pressed;
	end

endmodule

`default_nettype wire

FILE: src/dkcl_matcher.sv
`default_nettype none

// four-digit code matcher, fed one released key at a time
module dkcl_matcher (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic clear,
	input  wire logic push,
	input  wire logic [dkcl_pkg::DIGIT_W-1:0] digit,
	input  wire logic [dkcl_pkg::CODE_LEN-1:0][dkcl_pkg::DIGIT_W-1:0] code,
	output dkcl_pkg::match_stat_t stat
);

	logic [dkcl_pkg::POS_W-1:0] position_q;
	logic correct_q;
	logic [dkcl_pkg::POS_W-1:0] position_d;
	logic correct_d;
	logic completed;

	always_comb begin
		position_d = position_q;
		correct_d = correct_q;
		completed = 1'b0;
		if (clear) begin
			position_d = '0;
			correct_d = 1'b0;
		end else if (push && !correct_q) begin
			// a wrong digit restarts the match and is not retried as a first digit
			if (digit == code[position_q[1:0]]) begin
				position_d = position_q + {{(dkcl_pkg::POS_W-1){1'b0}}, 1'b1};
			end else begin
				position_d = '0;
			end
			if (position_d >= dkcl_pkg::POS_W'(dkcl_pkg::CODE_LEN)) begin
				position_d = dkcl_pkg::POS_W'(dkcl_pkg::CODE_LEN);
				correct_d = 1'b1;
				completed = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			correct_q <= 1'b0;
		end else begin
			position_q <= position_d;
			correct_q <= correct_d;
		end
	end

	assign stat.position = position_q;
	assign stat.correct = correct_q;
	assign stat.completed = completed;

endmodule

`default_nettype wire

FILE: src/debounced_keypad_code_lock.sv
`default_nettype none

// debounced keypad code lock
//
// input channel (in_valid / in_stall / in_data): one transaction per scan tick
// carries the active-low pin levels of the keys, or a clear request that
// resets code progress and relocks. output channel (out_valid / out_stall /
// out_data): exactly one result transaction per input transaction, in order.
// a scan tick walks the keys one per cycle through a single shared integrator
// unit, feeding each release straight into the code matcher; a tick passes
// from acceptance through the walk state and the finish state into the
// output register, while a clear goes straight to the finish state. the block
// takes a new transaction only once the last one has left the finish state.
// the finished result sits in an output register; the block goes back to
// accepting once that register has been loaded, so a stalled receiver only
// holds up the transaction after next. while out_valid and out_stall are
// both high the result register and out_valid hold.
// the configuration port (cfg_we, cfg_index, cfg_data) writes a register;
// it is to be written only while the block is idle, which the block itself does not enforce.
// reset clears integrators, pressed states and match progress, and puts the
// code digits to 0, debounce ceiling to 10 and press threshold to 5.
module debounced_keypad_code_lock (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire dkcl_pkg::in_t in_data,
	output logic out_valid,
	input  wire logic out_stall,
	output dkcl_pkg::out_t out_data,
	input  wire logic cfg_we,
	input  wire logic [dkcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dkcl_pkg::CFG_W-1:0] cfg_data
);

	// configuration registers
	logic [dkcl_pkg::CODE_LEN-1:0][dkcl_pkg::DIGIT_W-1:0] code_q;
	logic [dkcl_pkg::CFG_W-1:0] debounce_max_q;
	logic [dkcl_pkg::CFG_W-1:0] press_threshold_q;

	// key state
	logic [dkcl_pkg::CFG_W-1:0] integ_q [dkcl_pkg::NUM_KEYS];
	logic [dkcl_pkg::KEY_VEC_W-1:0] pressed_q;

	// per-transaction working registers
	logic [dkcl_pkg::KEY_VEC_W-1:0] pins_n_q;
	logic [dkcl_pkg::KEY_VEC_W-1:0] released_q;
	logic [dkcl_pkg::KEY_W-1:0] key_idx_q;
	logic newly_q;

	// sequencer
	dkcl_pkg::state_t state_q;
	dkcl_pkg::state_t state_d;
	logic accept;
	logic walk_en;
	logic load_out;

	// output register
	logic out_valid_q;
	dkcl_pkg::out_t out_q;

	dkcl_pkg::key_upd_t upd;
	dkcl_pkg::match_stat_t mstat;
	logic last_key;

	assign accept = in_valid && !in_stall;
	assign last_key = (key_idx_q == dkcl_pkg::KEY_W'(dkcl_pkg::NUM_KEYS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dkcl_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_data.action == dkcl_pkg::ACT_CLEAR) begin
						state_d = dkcl_pkg::ST_FINISH;
					end else begin
						state_d = dkcl_pkg::ST_WALK;
					end
				end
			end
			dkcl_pkg::ST_WALK: begin
				if (last_key) begin
					state_d = dkcl_pkg::ST_FINISH;
				end
			end
			dkcl_pkg::ST_FINISH: begin
				if (load_out) begin
					state_d = dkcl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dkcl_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		walk_en = 1'b0;
		load_out = 1'b0;
		case (state_q)
			dkcl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			dkcl_pkg::ST_WALK: begin
				walk_en = 1'b1;
			end
			dkcl_pkg::ST_FINISH: begin
				// the result register must be free or emptying this cycle
				load_out = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dkcl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			debounce_max_q <= dkcl_pkg::DEBOUNCE_MAX_RST;
			press_threshold_q <= dkcl_pkg::PRESS_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dkcl_pkg::REG_CODE_0: code_q[0] <= cfg_data;
				dkcl_pkg::REG_CODE_1: code_q[1] <= cfg_data;
				dkcl_pkg::REG_CODE_2: code_q[2] <= cfg_data;
				dkcl_pkg::REG_CODE_3: code_q[3] <= cfg_data;
				dkcl_pkg::REG_DEBOUNCE_MAX: debounce_max_q <= cfg_data;
				dkcl_pkg::REG_PRESS_THRESHOLD: press_threshold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// shared integrator unit, one key per cycle; keys beyond the pin field read as held
	dkcl_key_unit u_key_unit (
		.level          (integ_q[key_idx_q]),
		.held           (~pins_n_q[key_idx_q]),
		.was_pressed    (pressed_q[key_idx_q]),
		.debounce_max   (debounce_max_q),
		.press_threshold(press_threshold_q),
		.upd            (upd)
	);

	// releases go into the matcher in ascending key order as the walk passes them
	dkcl_matcher u_matcher (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (accept && (in_data.action == dkcl_pkg::ACT_CLEAR)),
		.push  (walk_en && upd.released),
		.digit (dkcl_pkg::DIGIT_W'(key_idx_q)),
		.code  (code_q),
		.stat  (mstat)
	);

	// key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < dkcl_pkg::NUM_KEYS; k++) begin
				integ_q[k] <= '0;
			end
			pressed_q <= '0;
		end else if (walk_en) begin
			integ_q[key_idx_q] <= upd.level;
			pressed_q[key_idx_q] <= upd.now_pressed;
		end
	end

	// walk control and per-transaction accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_idx_q <= '0;
			released_q <= '0;
			newly_q <= 1'b0;
		end else if (accept) begin
			key_idx_q <= '0;
			released_q <= '0;
			newly_q <= 1'b0;
		end else if (walk_en) begin
			if (!last_key) begin
				key_idx_q <= key_idx_q + {{(dkcl_pkg::KEY_W-1){1'b0}}, 1'b1};
			end
			released_q[key_idx_q] <= upd.released;
			if (mstat.completed) begin
				newly_q <= 1'b1;
			end
		end
	end

	// pin levels held for the walk; bits above the pin field stay low
	always_ff @(posedge clk) begin
		if (accept) begin
			pins_n_q <= dkcl_pkg::KEY_VEC_W'(in_data.key_pins_n);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.released_mask <= released_q[dkcl_pkg::MASK_W-1:0];
			out_q.pressed_mask <= pressed_q[dkcl_pkg::MASK_W-1:0];
			out_q.match_count <= mstat.position;
			out_q.unlocked <= mstat.correct;
			out_q.newly_unlocked <= newly_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire
